### hw/rtl/jmpc_pkg.sv
// ----------------------------------------------------------------------------
// jmpc_pkg
// Shared types, constants and saturation helpers of the joint motor PID
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package jmpc_pkg;

  // Fixed-point format of all data values
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned INTEG_W   = 48;

  // Shared unit operand and result widths
  localparam int unsigned OPA_W  = 49;
  localparam int unsigned OPB_W  = 31;
  localparam int unsigned PROD_W = OPA_W + OPB_W + 1;
  localparam int unsigned QUOT_W = 48;
  localparam int unsigned CNT_W  = 6;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(OPB_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);

  // pi and 2*pi rounded to nearest, wide enough for wrap arithmetic
  localparam logic signed [33:0] PI_Q     = 34'sd205887;
  localparam logic signed [33:0] TWO_PI_Q = 34'sd411775;

  typedef logic signed [DATA_W-1:0]  q_t;
  typedef logic signed [INTEG_W-1:0] integ_t;

  typedef enum logic [1:0] {
    MODE_POS = 2'd0,
    MODE_VEL = 2'd1,
    MODE_EFF = 2'd2,
    MODE_RSV = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE        = 3'd0,
    CFG_GAIN_P      = 3'd1,
    CFG_GAIN_I      = 3'd2,
    CFG_GAIN_D      = 3'd3,
    CFG_LOWER_LIMIT = 3'd4,
    CFG_UPPER_LIMIT = 3'd5,
    CFG_SPEED_CAP   = 3'd6,
    CFG_EFFORT_CAP  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } unit_op_e;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_ERR,
    SEQ_PROD,
    SEQ_INTEG,
    SEQ_MI_GO,
    SEQ_MI_WAIT,
    SEQ_DR_GO,
    SEQ_DR_WAIT,
    SEQ_MP_GO,
    SEQ_MP_WAIT,
    SEQ_DD_GO,
    SEQ_DD_WAIT,
    SEQ_MD_GO,
    SEQ_MD_WAIT,
    SEQ_SUM,
    SEQ_OUT
  } seq_state_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    mode_e       mode;
    logic [30:0] gain_p;
    logic [30:0] gain_i;
    logic [30:0] gain_d;
    q_t          lower_limit;
    q_t          upper_limit;
    logic [30:0] speed_cap;
    logic [30:0] effort_cap;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] measured_position;
    logic signed [31:0] play_offset;
    logic [15:0]        time_step;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] drive_value;
    logic               drive_kind;
    logic               drive_limited;
    logic signed [31:0] position_error;
  } out_beat_t;

  typedef struct packed {
    logic lim;
    q_t   val;
  } cap_t;

  // Saturate a 64-bit signed value to the data width
  function automatic q_t sat_q(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      return hi[DATA_W-1:0];
    end
    if (x < lo) begin
      return lo[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

  // Saturate a 49-bit sum to the integrator width
  function automatic integ_t sat_integ(input logic signed [INTEG_W:0] x);
    if (x[INTEG_W] != x[INTEG_W-1]) begin
      return {x[INTEG_W], {(INTEG_W-1){~x[INTEG_W]}}};
    end
    return x[INTEG_W-1:0];
  endfunction

  // Hold a value to +-cap and flag whether it moved
  function automatic cap_t cap_drive(input q_t v, input logic [30:0] c);
    q_t   cs;
    q_t   r;
    cap_t res;
    cs = $signed({1'b0, c});
    r  = v;
    if (r > cs) begin
      r = cs;
    end
    if (r < -cs) begin
      r = -cs;
    end
    res.val = r;
    res.lim = (r != v);
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/joint_motor_pid_controller.sv
// ----------------------------------------------------------------------------
// joint_motor_pid_controller
// Joint motor PID controller with anti-windup, signed Q16.16, one drive beat
// per tick.
// ----------------------------------------------------------------------------
// One tick beat at a time: the input stalls from acceptance until the result
// is loaded into the output register. Velocity mode bypasses the shared unit.
// The other modes run three products and a derivative divide, plus a reload
// divide when anti-windup reloads the integrator outside effort mode, on the
// single shared 50-bit adder, which resolves one bit of the 31-bit multiplier
// or of the 48-bit quotient each cycle. A new tick is accepted while the
// previous result still waits in the output register.
`default_nettype none

module joint_motor_pid_controller (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire jmpc_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output jmpc_pkg::out_beat_t      out_data_o
);

  jmpc_pkg::cfg_t cfg_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= jmpc_pkg::MODE_POS;
      cfg_q.gain_p      <= '0;
      cfg_q.gain_i      <= '0;
      cfg_q.gain_d      <= '0;
      cfg_q.lower_limit <= {1'b1, 31'b0};
      cfg_q.upper_limit <= {1'b0, {31{1'b1}}};
      cfg_q.speed_cap   <= '0;
      cfg_q.effort_cap  <= '0;
    end else if (cfg_we_i) begin
      unique case (jmpc_pkg::cfg_idx_e'(cfg_index_i))
        jmpc_pkg::CFG_MODE:        cfg_q.mode        <= jmpc_pkg::mode_e'(cfg_wdata_i[1:0]);
        jmpc_pkg::CFG_GAIN_P:      cfg_q.gain_p      <= cfg_wdata_i[30:0];
        jmpc_pkg::CFG_GAIN_I:      cfg_q.gain_i      <= cfg_wdata_i[30:0];
        jmpc_pkg::CFG_GAIN_D:      cfg_q.gain_d      <= cfg_wdata_i[30:0];
        jmpc_pkg::CFG_LOWER_LIMIT: cfg_q.lower_limit <= $signed(cfg_wdata_i);
        jmpc_pkg::CFG_UPPER_LIMIT: cfg_q.upper_limit <= $signed(cfg_wdata_i);
        jmpc_pkg::CFG_SPEED_CAP:   cfg_q.speed_cap   <= cfg_wdata_i[30:0];
        jmpc_pkg::CFG_EFFORT_CAP:  cfg_q.effort_cap  <= cfg_wdata_i[30:0];
        default:                   cfg_q.mode        <= cfg_q.mode;
      endcase
    end
  end

  // Tick sequencer with shared arithmetic unit
  jmpc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### hw/rtl/jmpc_shared_unit.sv
// ----------------------------------------------------------------------------
// jmpc_shared_unit
// One 50-bit adder/subtractor, stepped once per cycle: shift-add multiply
// (signed A by unsigned B, one B bit per cycle) or restoring divide
// (unsigned, one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module jmpc_shared_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire jmpc_pkg::unit_req_t                  req_i,
  input  wire logic signed [jmpc_pkg::OPA_W-1:0]    opa_i,
  input  wire logic [jmpc_pkg::OPB_W-1:0]           opb_i,
  output logic                                      done_o,
  output logic                                      busy_o,
  output logic signed [jmpc_pkg::PROD_W-1:0]        prod_o,
  output logic [jmpc_pkg::QUOT_W-1:0]               quot_o
);

  localparam int unsigned HI_W = jmpc_pkg::OPA_W + 1;

  logic signed [HI_W-1:0]           hi_q, hi_d;
  logic [jmpc_pkg::QUOT_W-1:0]      lo_q, lo_d;
  logic [jmpc_pkg::OPA_W-1:0]       opd_q;
  logic [jmpc_pkg::CNT_W-1:0]       cnt_q;
  logic                             busy_q, done_q;
  jmpc_pkg::unit_op_e               op_q;

  logic [HI_W-1:0] add_x, add_y, add_sum;
  logic            add_sub;
  logic [HI_W-1:0] shifted;
  logic [HI_W-1:0] mul_hi;
  logic            div_ge;
  logic            last;

  // Shared adder
  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + HI_W'(add_sub);

  // Operand select and step result
  always_comb begin
    shifted = {hi_q[HI_W-2:0], lo_q[jmpc_pkg::QUOT_W-1]};
    mul_hi  = '0;
    div_ge  = 1'b0;
    hi_d    = hi_q;
    lo_d    = lo_q;
    if (op_q == jmpc_pkg::UOP_MUL) begin
      add_x   = hi_q;
      add_y   = {opd_q[jmpc_pkg::OPA_W-1], opd_q};
      add_sub = 1'b0;
      mul_hi  = lo_q[0] ? add_sum : hi_q;
      hi_d    = {mul_hi[HI_W-1], mul_hi[HI_W-1:1]};
      lo_d    = {lo_q[jmpc_pkg::QUOT_W-1:jmpc_pkg::OPB_W], mul_hi[0],
                 lo_q[jmpc_pkg::OPB_W-1:1]};
    end else begin
      add_x   = shifted;
      add_y   = {1'b0, opd_q};
      add_sub = 1'b1;
      div_ge  = ~add_sum[HI_W-1];
      hi_d    = div_ge ? add_sum : shifted;
      lo_d    = {lo_q[jmpc_pkg::QUOT_W-2:0], div_ge};
    end
  end

  assign last = (op_q == jmpc_pkg::UOP_MUL) ? (cnt_q == jmpc_pkg::MUL_LAST)
                                            : (cnt_q == jmpc_pkg::DIV_LAST);

  // Control: start, count, finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= jmpc_pkg::UOP_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then step
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      hi_q <= '0;
      if (req_i.op == jmpc_pkg::UOP_MUL) begin
        opd_q <= opa_i;
        lo_q  <= {{(jmpc_pkg::QUOT_W-jmpc_pkg::OPB_W){1'b0}}, opb_i};
      end else begin
        opd_q <= {{(jmpc_pkg::OPA_W-jmpc_pkg::OPB_W){1'b0}}, opb_i};
        lo_q  <= opa_i[jmpc_pkg::QUOT_W-1:0];
      end
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign busy_o = busy_q;
  assign prod_o = {hi_q, lo_q[jmpc_pkg::OPB_W-1:0]};
  assign quot_o = lo_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("shared unit started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("done without a finished run");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= jmpc_pkg::DIV_LAST)
    else $error("step count out of range");
`endif

endmodule

`default_nettype wire

### hw/rtl/jmpc_seq.sv
// ----------------------------------------------------------------------------
// jmpc_seq
// Tick sequencer: computes the error, updates the integrator and walks the
// shared unit through the I, anti-windup, P and D terms, then registers the
// result beat; velocity mode skips to the result with the capped target.
// ----------------------------------------------------------------------------
`default_nettype none

module jmpc_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire jmpc_pkg::cfg_t      cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire jmpc_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output jmpc_pkg::out_beat_t      out_data_o
);

  jmpc_pkg::seq_state_e state_q, state_d;

  // Tick operands and intermediate terms
  jmpc_pkg::q_t        target_q, pos_q, err_q, prev_q;
  jmpc_pkg::q_t        iterm_q, pterm_q, dterm_q, drive_q;
  logic [15:0]         dt_q;
  jmpc_pkg::integ_t    integ_q, eprod_q;
  logic signed [33:0]  dquot_q;
  logic                lim_q, kind_q, reload_neg_q, diff_neg_q;
  logic                out_valid_q;
  jmpc_pkg::out_beat_t out_q;

  // Shared unit hookup
  jmpc_pkg::unit_req_t                      req;
  logic signed [jmpc_pkg::OPA_W-1:0]        opa;
  logic [jmpc_pkg::OPB_W-1:0]               opb;
  logic                                     unit_done, unit_busy;
  logic signed [jmpc_pkg::PROD_W-1:0]       prod;
  logic [jmpc_pkg::QUOT_W-1:0]              quot;

  jmpc_shared_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (unit_done),
    .busy_o (unit_busy),
    .prod_o (prod),
    .quot_o (quot)
  );

  logic                   in_acc, out_free, is_eff;
  logic signed [32:0]     pos_sum;
  jmpc_pkg::q_t           t_clamp;
  logic signed [33:0]     t_wrap, e_wide;
  jmpc_pkg::q_t           err_new;
  jmpc_pkg::cap_t         vel_cap, sum_cap;
  logic signed [63:0]     ifull, cap64;
  logic                   need_reload;
  logic signed [32:0]     diff;
  logic [32:0]            diff_mag;
  logic signed [33:0]     dsum;
  jmpc_pkg::q_t           sum_sat;
  logic signed [jmpc_pkg::INTEG_W:0] prod49, integ_sum;

  assign in_acc   = in_valid_i && (state_q == jmpc_pkg::SEQ_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_eff   = (cfg_i.mode == jmpc_pkg::MODE_EFF);
  assign pos_sum  = {in_data_i.measured_position[31], in_data_i.measured_position}
                  + {in_data_i.play_offset[31], in_data_i.play_offset};

  // Clamp, wrap and form the error
  always_comb begin
    t_clamp = target_q;
    if (t_clamp > cfg_i.upper_limit) begin
      t_clamp = cfg_i.upper_limit;
    end
    if (t_clamp < cfg_i.lower_limit) begin
      t_clamp = cfg_i.lower_limit;
    end
    t_wrap = {{2{t_clamp[31]}}, t_clamp};
    if (is_eff) begin
      if (t_wrap > jmpc_pkg::TWO_PI_Q) begin
        t_wrap = '0;
      end else if (t_wrap > jmpc_pkg::PI_Q) begin
        t_wrap = t_wrap - jmpc_pkg::TWO_PI_Q;
      end else if (t_wrap < -jmpc_pkg::TWO_PI_Q) begin
        t_wrap = '0;
      end else if (t_wrap < -jmpc_pkg::PI_Q) begin
        t_wrap = t_wrap + jmpc_pkg::TWO_PI_Q;
      end
    end
    e_wide = t_wrap - {{2{pos_q[31]}}, pos_q};
    if (is_eff) begin
      if (e_wide > jmpc_pkg::PI_Q) begin
        e_wide = e_wide - jmpc_pkg::TWO_PI_Q;
      end else if (e_wide < -jmpc_pkg::PI_Q) begin
        e_wide = e_wide + jmpc_pkg::TWO_PI_Q;
      end
    end
    err_new = jmpc_pkg::sat_q({{30{e_wide[33]}}, e_wide});
  end

  assign vel_cap = jmpc_pkg::cap_drive(target_q, cfg_i.speed_cap);

  // Integrator product and sum
  assign prod49    = err_q * $signed({1'b0, dt_q});
  assign integ_sum = {integ_q[jmpc_pkg::INTEG_W-1], integ_q}
                   + {eprod_q[jmpc_pkg::INTEG_W-1], eprod_q};

  // Scaled product and anti-windup test
  assign ifull = prod[jmpc_pkg::FRAC_BITS +: 64];
  assign cap64 = $signed({33'b0, cfg_i.speed_cap});
  assign need_reload = !is_eff && (cfg_i.gain_i != '0) && (ifull > cap64 || ifull < -cap64);

  // Derivative difference magnitude
  assign diff     = {err_q[31], err_q} - {prev_q[31], prev_q};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

  // Final sum and cap
  assign dsum    = {{2{pterm_q[31]}}, pterm_q} + {{2{iterm_q[31]}}, iterm_q}
                 + {{2{dterm_q[31]}}, dterm_q};
  assign sum_sat = jmpc_pkg::sat_q({{30{dsum[33]}}, dsum});
  assign sum_cap = jmpc_pkg::cap_drive(sum_sat, is_eff ? cfg_i.effort_cap : cfg_i.speed_cap);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jmpc_pkg::SEQ_IDLE:    if (in_acc) state_d = jmpc_pkg::SEQ_ERR;
      jmpc_pkg::SEQ_ERR: begin
        state_d = (cfg_i.mode == jmpc_pkg::MODE_VEL) ? jmpc_pkg::SEQ_OUT
                                                     : jmpc_pkg::SEQ_PROD;
      end
      jmpc_pkg::SEQ_PROD:    state_d = jmpc_pkg::SEQ_INTEG;
      jmpc_pkg::SEQ_INTEG:   state_d = jmpc_pkg::SEQ_MI_GO;
      jmpc_pkg::SEQ_MI_GO:   state_d = jmpc_pkg::SEQ_MI_WAIT;
      jmpc_pkg::SEQ_MI_WAIT: begin
        if (unit_done) begin
          state_d = need_reload ? jmpc_pkg::SEQ_DR_GO : jmpc_pkg::SEQ_MP_GO;
        end
      end
      jmpc_pkg::SEQ_DR_GO:   state_d = jmpc_pkg::SEQ_DR_WAIT;
      jmpc_pkg::SEQ_DR_WAIT: if (unit_done) state_d = jmpc_pkg::SEQ_MP_GO;
      jmpc_pkg::SEQ_MP_GO:   state_d = jmpc_pkg::SEQ_MP_WAIT;
      jmpc_pkg::SEQ_MP_WAIT: if (unit_done) state_d = jmpc_pkg::SEQ_DD_GO;
      jmpc_pkg::SEQ_DD_GO:   state_d = jmpc_pkg::SEQ_DD_WAIT;
      jmpc_pkg::SEQ_DD_WAIT: if (unit_done) state_d = jmpc_pkg::SEQ_MD_GO;
      jmpc_pkg::SEQ_MD_GO:   state_d = jmpc_pkg::SEQ_MD_WAIT;
      jmpc_pkg::SEQ_MD_WAIT: if (unit_done) state_d = jmpc_pkg::SEQ_SUM;
      jmpc_pkg::SEQ_SUM:     state_d = jmpc_pkg::SEQ_OUT;
      jmpc_pkg::SEQ_OUT:     if (out_free) state_d = jmpc_pkg::SEQ_IDLE;
      default:               state_d = jmpc_pkg::SEQ_IDLE;
    endcase
  end

  // Unit requests and operands
  always_comb begin
    req.start = 1'b0;
    req.op    = jmpc_pkg::UOP_MUL;
    opa       = '0;
    opb       = '0;
    unique case (state_q)
      jmpc_pkg::SEQ_MI_GO: begin
        req.start = 1'b1;
        opa       = {integ_q[jmpc_pkg::INTEG_W-1], integ_q};
        opb       = cfg_i.gain_i;
      end
      jmpc_pkg::SEQ_DR_GO: begin
        req.start = 1'b1;
        req.op    = jmpc_pkg::UOP_DIV;
        opa       = {2'b00, cfg_i.speed_cap, {jmpc_pkg::FRAC_BITS{1'b0}}};
        opb       = cfg_i.gain_i;
      end
      jmpc_pkg::SEQ_MP_GO: begin
        req.start = 1'b1;
        opa       = {{(jmpc_pkg::OPA_W-32){err_q[31]}}, err_q};
        opb       = cfg_i.gain_p;
      end
      jmpc_pkg::SEQ_DD_GO: begin
        req.start = 1'b1;
        req.op    = jmpc_pkg::UOP_DIV;
        opa       = {{(jmpc_pkg::OPA_W-33){1'b0}}, diff_mag};
        opb       = {15'b0, dt_q};
      end
      jmpc_pkg::SEQ_MD_GO: begin
        req.start = 1'b1;
        opa       = {{(jmpc_pkg::OPA_W-34){dquot_q[33]}}, dquot_q};
        opb       = cfg_i.gain_d;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  // Control state and persistent controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jmpc_pkg::SEQ_IDLE;
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == jmpc_pkg::SEQ_INTEG) begin
        integ_q <= jmpc_pkg::sat_integ(integ_sum);
      end
      if (state_q == jmpc_pkg::SEQ_DR_WAIT && unit_done) begin
        integ_q <= reload_neg_q ? -$signed(quot) : $signed(quot);
      end
      if (state_q == jmpc_pkg::SEQ_SUM) begin
        prev_q <= err_q;
      end
      if (state_q == jmpc_pkg::SEQ_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tick datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      target_q <= in_data_i.target;
      pos_q    <= jmpc_pkg::sat_q({{31{pos_sum[32]}}, pos_sum});
      dt_q     <= (in_data_i.time_step == '0) ? 16'd1 : in_data_i.time_step;
    end
    unique case (state_q)
      jmpc_pkg::SEQ_ERR: begin
        kind_q <= is_eff;
        if (cfg_i.mode == jmpc_pkg::MODE_VEL) begin
          err_q   <= '0;
          drive_q <= vel_cap.val;
          lim_q   <= vel_cap.lim;
        end else begin
          err_q <= err_new;
        end
      end
      jmpc_pkg::SEQ_PROD: begin
        eprod_q <= prod49[jmpc_pkg::INTEG_W-1:0];
      end
      jmpc_pkg::SEQ_MI_WAIT: begin
        if (unit_done) begin
          reload_neg_q <= !(ifull > cap64);
          iterm_q      <= is_eff ? jmpc_pkg::sat_q(ifull) : ifull[31:0];
        end
      end
      jmpc_pkg::SEQ_DR_WAIT: begin
        if (unit_done) begin
          iterm_q <= reload_neg_q ? -$signed({1'b0, cfg_i.speed_cap})
                                  : $signed({1'b0, cfg_i.speed_cap});
        end
      end
      jmpc_pkg::SEQ_MP_WAIT: begin
        if (unit_done) begin
          pterm_q <= jmpc_pkg::sat_q(ifull);
        end
      end
      jmpc_pkg::SEQ_DD_GO: begin
        diff_neg_q <= diff[32];
      end
      jmpc_pkg::SEQ_DD_WAIT: begin
        if (unit_done) begin
          dquot_q <= diff_neg_q ? -$signed({1'b0, quot[32:0]})
                                : $signed({1'b0, quot[32:0]});
        end
      end
      jmpc_pkg::SEQ_MD_WAIT: begin
        if (unit_done) begin
          dterm_q <= jmpc_pkg::sat_q(ifull);
        end
      end
      jmpc_pkg::SEQ_SUM: begin
        drive_q <= sum_cap.val;
        lim_q   <= sum_cap.lim;
      end
      jmpc_pkg::SEQ_OUT: begin
        if (out_free) begin
          out_q.drive_value    <= drive_q;
          out_q.drive_kind     <= kind_q;
          out_q.drive_limited  <= lim_q;
          out_q.position_error <= err_q;
        end
      end
      default: begin
        eprod_q <= eprod_q;
      end
    endcase
  end

  assign in_stall_o  = (state_q != jmpc_pkg::SEQ_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == jmpc_pkg::SEQ_ERR)
    else $error("accepted tick did not start");
  a_prev_only_at_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(prev_q) |-> $past(state_q) == jmpc_pkg::SEQ_SUM)
    else $error("previous error changed outside the sum step");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == jmpc_pkg::SEQ_MI_WAIT || state_q == jmpc_pkg::SEQ_DR_WAIT ||
                   state_q == jmpc_pkg::SEQ_MP_WAIT || state_q == jmpc_pkg::SEQ_DD_WAIT ||
                   state_q == jmpc_pkg::SEQ_MD_WAIT))
    else $error("unit finished outside a wait state");
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !unit_busy)
    else $error("unit request while the unit is busy");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the joint motor PID controller against a cycle-free predictor of the
// control law, with random idling on both channels and several register sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;
  localparam logic signed [63:0] PI_W     = 64'sd205887;
  localparam logic signed [63:0] TWO_PI_W = 64'sd411775;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  jmpc_pkg::cfg_idx_e  cfg_index;
  logic [31:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  jmpc_pkg::in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  jmpc_pkg::out_beat_t out_data;

  joint_motor_pid_controller DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  // Predictor copy of registers and controller state
  jmpc_pkg::mode_e       p_mode;
  logic signed [63:0] p_kp, p_ki, p_kd, p_lo, p_hi, p_vcap, p_ecap;
  logic signed [63:0] p_integ, p_prev;

  jmpc_pkg::in_beat_t  tick_queue[$];
  jmpc_pkg::out_beat_t drive_queue[$];
  int  errors;
  int  send_idle_pct;
  int  stall_pct;
  int  watchdog;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [63:0] sat_w(input logic signed [63:0] x, input int w);
    logic signed [63:0] hi;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    if (x > hi) return hi;
    if (x < -hi - 64'sd1) return -hi - 64'sd1;
    return x;
  endfunction

  // Fixed-point product, floor, saturated to w bits
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b, input int w);
    logic signed [127:0] prod;
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    prod = (128'(a) * 128'(b)) >>> jmpc_pkg::FRAC_BITS;
    hi = (128'sd1 <<< (w - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (prod > hi) return hi[63:0];
    if (prod < lo) return lo[63:0];
    return prod[63:0];
  endfunction

  function automatic logic signed [63:0] hold_cap(input logic signed [63:0] v,
                                                  input logic signed [63:0] c,
                                                  output logic moved);
    logic signed [63:0] r;
    r = v;
    if (r > c) r = c;
    if (r < -c) r = -c;
    moved = (r != v);
    return r;
  endfunction

  function automatic logic signed [63:0] clamp_target(input logic signed [63:0] t);
    logic signed [63:0] r;
    r = t;
    if (r > p_hi) r = p_hi;
    if (r < p_lo) r = p_lo;
    return r;
  endfunction

  task automatic predict_drive(input jmpc_pkg::in_beat_t b);
    logic signed [63:0] tgt, pos, dt, t, err, pt, it, dtm, drv, reload;
    logic lim;
    jmpc_pkg::out_beat_t o;
    tgt = 64'(b.target);
    pos = sat_w(64'(b.measured_position) + 64'(b.play_offset), 32);
    dt  = 64'(b.time_step);
    if (dt == 0) dt = 1;
    err = 0;
    lim = 1'b0;
    if (p_mode == jmpc_pkg::MODE_VEL) begin
      drv = hold_cap(tgt, p_vcap, lim);
      o.drive_kind = 1'b0;
    end else if (p_mode == jmpc_pkg::MODE_EFF) begin
      t = clamp_target(tgt);
      if (t > TWO_PI_W) t = 0;
      else if (t > PI_W) t = t - TWO_PI_W;
      else if (t < -TWO_PI_W) t = 0;
      else if (t < -PI_W) t = t + TWO_PI_W;
      err = t - pos;
      if (err > PI_W) err = err - TWO_PI_W;
      else if (err < -PI_W) err = err + TWO_PI_W;
      err = sat_w(err, 32);
      p_integ = sat_w(p_integ + err * dt, 48);
      pt  = fx_mul(err, p_kp, 32);
      it  = fx_mul(p_integ, p_ki, 32);
      dtm = fx_mul((err - p_prev) / dt, p_kd, 32);
      p_prev = err;
      drv = hold_cap(sat_w(pt + it + dtm, 32), p_ecap, lim);
      o.drive_kind = 1'b1;
    end else begin
      t = clamp_target(tgt);
      err = sat_w(t - pos, 32);
      p_integ = sat_w(p_integ + err * dt, 48);
      it = fx_mul(p_integ, p_ki, 64);
      if (p_ki != 0) begin
        reload = sat_w((p_vcap <<< jmpc_pkg::FRAC_BITS) / p_ki, 48);
        if (it > p_vcap) begin
          it = p_vcap;
          p_integ = reload;
        end
        if (it < -p_vcap) begin
          it = -p_vcap;
          p_integ = -reload;
        end
      end
      pt  = fx_mul(err, p_kp, 32);
      dtm = fx_mul((err - p_prev) / dt, p_kd, 32);
      p_prev = err;
      drv = hold_cap(sat_w(pt + it + dtm, 32), p_vcap, lim);
      o.drive_kind = 1'b0;
    end
    o.drive_value    = drv[31:0];
    o.drive_limited  = lim;
    o.position_error = err[31:0];
    drive_queue.push_back(o);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Write one register at a clock edge and mirror it
  task automatic write_reg(input jmpc_pkg::cfg_idx_e idx, input logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      jmpc_pkg::CFG_MODE:        p_mode = jmpc_pkg::mode_e'(v[1:0]);
      jmpc_pkg::CFG_GAIN_P:      p_kp = 64'(v[30:0]);
      jmpc_pkg::CFG_GAIN_I:      p_ki = 64'(v[30:0]);
      jmpc_pkg::CFG_GAIN_D:      p_kd = 64'(v[30:0]);
      jmpc_pkg::CFG_LOWER_LIMIT: p_lo = 64'($signed(v));
      jmpc_pkg::CFG_UPPER_LIMIT: p_hi = 64'($signed(v));
      jmpc_pkg::CFG_SPEED_CAP:   p_vcap = 64'(v[30:0]);
      default:                   p_ecap = 64'(v[30:0]);
    endcase
  endtask

  task automatic drain;
    while (tick_queue.size() != 0 || drive_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q(input int spread);
    case (spread)
      0: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      1: return $urandom();
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic jmpc_pkg::in_beat_t rand_tick(input int spread);
    jmpc_pkg::in_beat_t b;
    b.target            = rand_q(spread);
    b.measured_position = rand_q(spread);
    b.play_offset       = ($urandom_range(0, 3) == 0) ? rand_q(spread) : rand_q(2);
    b.time_step         = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(1, 20));
    return b;
  endfunction

  function automatic jmpc_pkg::in_beat_t mk(input logic [31:0] t, input logic [31:0] m,
                                            input logic [31:0] o, input logic [15:0] d);
    jmpc_pkg::in_beat_t b;
    b.target = t;
    b.measured_position = m;
    b.play_offset = o;
    b.time_step = d;
    return b;
  endfunction

  task automatic load_set(input jmpc_pkg::mode_e m, input logic [31:0] kp,
                          input logic [31:0] ki,
                          input logic [31:0] kd, input logic [31:0] lo,
                          input logic [31:0] hi, input logic [31:0] vc,
                          input logic [31:0] ec);
    write_reg(jmpc_pkg::CFG_MODE, 32'(m));
    write_reg(jmpc_pkg::CFG_GAIN_P, kp);
    write_reg(jmpc_pkg::CFG_GAIN_I, ki);
    write_reg(jmpc_pkg::CFG_GAIN_D, kd);
    write_reg(jmpc_pkg::CFG_LOWER_LIMIT, lo);
    write_reg(jmpc_pkg::CFG_UPPER_LIMIT, hi);
    write_reg(jmpc_pkg::CFG_SPEED_CAP, vc);
    write_reg(jmpc_pkg::CFG_EFFORT_CAP, ec);
  endtask

  // Reset and stimulus
  initial begin
    int n;
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = jmpc_pkg::CFG_MODE;
    cfg_wdata = '0;
    p_mode = jmpc_pkg::MODE_POS;
    p_kp = 0; p_ki = 0; p_kd = 0;
    p_lo = -64'sd2147483648; p_hi = 64'sd2147483647;
    p_vcap = 0; p_ecap = 0;
    p_integ = 0; p_prev = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, then extremes in every mode
    tick_queue.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd0));
    drain();
    load_set(jmpc_pkg::MODE_POS, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
             32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    tick_queue.push_back(mk(32'h7FFF_FFFF, 32'h0, 32'h0, 16'd1));
    tick_queue.push_back(mk(32'h8000_0000, 32'h0, 32'h0, 16'hFFFF));
    tick_queue.push_back(mk(32'h0, 32'h0, 32'h0, 16'd1));
    tick_queue.push_back(mk(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1));
    tick_queue.push_back(mk(32'h0, 32'h8000_0000, 32'h8000_0000, 16'd0));
    drain();
    load_set(jmpc_pkg::MODE_RSV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    tick_queue.push_back(mk(32'h0, 32'h0001_0000, 32'h0, 16'd3));
    tick_queue.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hFFFF));
    drain();
    load_set(jmpc_pkg::MODE_VEL, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0001_0000, 32'h0);
    tick_queue.push_back(mk(32'h7FFF_FFFF, 32'h0, 32'h0, 16'd1));
    tick_queue.push_back(mk(32'h8000_0000, 32'h0, 32'h0, 16'd1));
    tick_queue.push_back(mk(32'h0000_8000, 32'h0, 32'h0, 16'd1));
    drain();
    load_set(jmpc_pkg::MODE_EFF, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h0, 32'h0004_0000);
    tick_queue.push_back(mk(32'h0007_0000, 32'h0, 32'h0, 16'd1));
    tick_queue.push_back(mk(32'h0004_0000, 32'h0, 32'h0, 16'd2));
    tick_queue.push_back(mk(32'hFFFC_0000, 32'h0, 32'h0, 16'd2));
    tick_queue.push_back(mk(32'hFFF9_0000, 32'h0, 32'h0, 16'd2));
    tick_queue.push_back(mk(32'h0003_0000, 32'hFFFD_0000, 32'h0, 16'd5));
    tick_queue.push_back(mk(32'hFFFD_0000, 32'h0003_0000, 32'h0, 16'd5));
    tick_queue.push_back(mk(32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 16'd1));
    drain();

    // Random phases under varied register sets and idling
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      load_set(jmpc_pkg::mode_e'($urandom_range(0, 3)),
               ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 4 << 16),
               ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 1 << 16),
               ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 4 << 16),
               ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : -$urandom_range(0, 8 << 16),
               ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 8 << 16),
               ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 6 << 16),
               ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 6 << 16));
      n = 50;
      for (int k = 0; k < n; k++) begin
        tick_queue.push_back(rand_tick($urandom_range(0, 5) == 0 ? 1 :
                                       ($urandom_range(0, 1) ? 0 : 2)));
        // Hold the sender until every pending drive beat has come back
        if (ph == 5 && k == 25) begin
          while (tick_queue.size() != 0 || drive_queue.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Driver: present the head tick, predict on acceptance
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_drive(in_data);
        void'(tick_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (((in_valid && !in_stall) ? tick_queue.size() : tick_queue.size() + 1) > 0
                   && tick_queue.size() > ((in_valid && !in_stall) ? 0 : -1)
                   && tick_queue.size() != 0
                   && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= tick_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each drive beat with the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    jmpc_pkg::out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      watchdog  <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (out_valid && !out_stall) begin
        watchdog <= 0;
        if (drive_queue.size() == 0) begin
          report("unexpected beat", out_data.drive_value, 32'h0);
        end else begin
          want = drive_queue.pop_front();
          if (out_data.drive_value !== want.drive_value)
            report("drive_value", out_data.drive_value, want.drive_value);
          if (out_data.drive_kind !== want.drive_kind)
            report("drive_kind", 32'(out_data.drive_kind), 32'(want.drive_kind));
          if (out_data.drive_limited !== want.drive_limited)
            report("drive_limited", 32'(out_data.drive_limited), 32'(want.drive_limited));
          if (out_data.position_error !== want.position_error)
            report("position_error", out_data.position_error, want.position_error);
        end
      end else if (in_valid && !in_stall) begin
        watchdog <= 0;
      end else if (watchdog >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        watchdog <= watchdog + 1;
      end
    end
  end

endmodule
